>>> src/ibwt_pkg.sv
package ibwt_pkg;

  localparam int BLOCK_SIZE_DEF    = 4096;
  localparam int ALPHABET_SIZE_DEF = 256;

  localparam int PIDX_W = 12;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

>>> src/inverse_bwt_decoder.sv
// Channel  Handshake            Payload
// -------  -------------------  -------------------------------------
// in       in_valid / in_stall  cmd, primary_index, data_byte
// out      out_valid/ out_stall decoded_byte, last_byte, status
//
// A header or an unused command is handled in the idle state; a data byte adds a
// read-modify-write of its symbol count in the count memory.
// A read waits on the registered read of the byte and next-row memories, unless it
// only reports a status. The first read of a block adds a prefix pass over the
// ALPHABET_SIZE symbol counts and a table pass over the block.
// Reset is synchronous; the symbol counts have per-entry valid bits that reset and a
// header clear at once, so there is no clearing pass. The byte and next-row memories
// are not reset. A result waiting in the output register does not block new requests
// that produce no result.
module inverse_bwt_decoder #(
  parameter int BLOCK_SIZE    = ibwt_pkg::BLOCK_SIZE_DEF,
  parameter int ALPHABET_SIZE = ibwt_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ibwt_pkg::cmd_t              cmd,
  input  logic [ibwt_pkg::PIDX_W-1:0] primary_index,
  input  logic [ibwt_pkg::BYTE_W-1:0] data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ibwt_pkg::BYTE_W-1:0] decoded_byte,
  output logic                        last_byte,
  output ibwt_pkg::status_t           status
);
  import ibwt_pkg::*;

  localparam int AW = $clog2(BLOCK_SIZE);
  localparam int CW = $clog2(BLOCK_SIZE + 1);
  localparam int SW = $clog2(ALPHABET_SIZE);
  localparam int RW = $clog2(ALPHABET_SIZE + 1);
  localparam int XW = (CW > PIDX_W) ? CW : PIDX_W;

  typedef enum logic [8:0] {
    S_IDLE        = 9'b000000001,
    S_COUNT       = 9'b000000010,
    S_PREFIX      = 9'b000000100,
    S_SCAN        = 9'b000001000,
    S_CURSOR      = 9'b000010000,
    S_CURSOR_WAIT = 9'b000100000,
    S_EMIT_RD     = 9'b001000000,
    S_EMIT        = 9'b010000000,
    S_OUT         = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]            blk_len;
  logic [CW-1:0]            emitted;
  logic [PIDX_W-1:0]        start_row;
  logic [AW-1:0]            cursor;
  logic                     built;
  logic [ALPHABET_SIZE-1:0] cnt_vld;

  // Memories
  logic [BYTE_W-1:0] byte_mem [BLOCK_SIZE];
  logic [BYTE_W-1:0] bs_rdata;
  logic [AW-1:0]     bs_raddr;
  logic              bs_we;

  logic [AW-1:0] nrt_mem [BLOCK_SIZE];
  logic [AW-1:0] nrt_rdata;
  logic [AW-1:0] nrt_raddr;
  logic          nrt_we;
  logic [AW-1:0] nrt_waddr;
  logic [AW-1:0] nrt_wdata;

  logic [CW-1:0] cnt_mem [ALPHABET_SIZE];
  logic [CW-1:0] cnt_rdata;
  logic [SW-1:0] cnt_raddr;
  logic          cnt_we;
  logic [SW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  // Data byte count update
  logic [SW-1:0] cnt_sym;
  logic          cnt_rv;

  // Prefix pass
  logic [RW-1:0] sweep;
  logic          p_vld;
  logic [SW-1:0] p_sym;
  logic          p_v;
  logic [CW-1:0] psum;

  // Table pass pipeline
  logic [CW-1:0] scan_idx;
  logic          a_vld;
  logic [AW-1:0] a_idx;
  logic          b_vld;
  logic [AW-1:0] b_idx;
  logic [SW-1:0] b_sym;
  logic          f_vld;
  logic [SW-1:0] f_sym;
  logic [CW-1:0] f_val;

  logic [BYTE_W-1:0] res_byte;
  logic              res_last;
  status_t           res_status;

  logic          data_ok;
  logic          read_empty;
  logic          row_in_range;
  logic          sweep_more;
  logic          scan_more;
  logic [CW-1:0] scan_pos;
  logic          out_free;

  assign in_stall     = (state != S_IDLE);
  assign out_free     = !out_valid || !out_stall;
  assign data_ok      = !built && (blk_len < CW'(BLOCK_SIZE))
                        && ({1'b0, data_byte} < (BYTE_W + 1)'(ALPHABET_SIZE));
  assign read_empty   = (blk_len == '0) || (emitted >= blk_len);
  assign row_in_range = XW'(start_row) < XW'(blk_len);
  assign sweep_more   = sweep < RW'(ALPHABET_SIZE);
  assign scan_more    = scan_idx < blk_len;

  // The count read for a symbol misses the write made by the previous byte, so that
  // value is forwarded when the symbols match.
  assign scan_pos = (f_vld && (f_sym == b_sym)) ? f_val : cnt_rdata;

  assign bs_we    = (state == S_IDLE) && in_valid && (cmd == CMD_DATA) && data_ok;
  assign bs_raddr = (state == S_SCAN) ? scan_idx[AW-1:0] : cursor;

  assign nrt_raddr = (state == S_CURSOR) ? AW'(start_row) : cursor;
  assign nrt_we    = (state == S_SCAN) && b_vld;
  assign nrt_waddr = scan_pos[AW-1:0];
  assign nrt_wdata = b_idx;

  always_comb begin
    cnt_raddr = data_byte[SW-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = cnt_sym;
    cnt_wdata = (cnt_rv ? cnt_rdata : '0) + CW'(1);
    if (state == S_PREFIX) begin
      cnt_raddr = sweep[SW-1:0];
      cnt_we    = p_vld;
      cnt_waddr = p_sym;
      cnt_wdata = psum;
    end else if (state == S_SCAN) begin
      cnt_raddr = bs_rdata[SW-1:0];
      cnt_we    = b_vld;
      cnt_waddr = b_sym;
      cnt_wdata = scan_pos + CW'(1);
    end else if (state == S_COUNT) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bs_we) begin
      byte_mem[blk_len[AW-1:0]] <= data_byte;
    end
    bs_rdata <= byte_mem[bs_raddr];
  end

  always_ff @(posedge clk) begin
    if (nrt_we) begin
      nrt_mem[nrt_waddr] <= nrt_wdata;
    end
    nrt_rdata <= nrt_mem[nrt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            CMD_HEADER: state_next = S_IDLE;
            CMD_DATA:   state_next = data_ok ? S_COUNT : S_IDLE;
            CMD_READ: begin
              if (read_empty) begin
                state_next = S_OUT;
              end else if (!built) begin
                state_next = S_PREFIX;
              end else if (!row_in_range) begin
                state_next = S_OUT;
              end else begin
                state_next = S_EMIT;
              end
            end
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_COUNT:       state_next = S_IDLE;
      S_PREFIX:      state_next = (!sweep_more && !p_vld) ? S_SCAN : S_PREFIX;
      S_SCAN:        state_next = (!scan_more && !a_vld && !b_vld) ? S_CURSOR : S_SCAN;
      S_CURSOR:      state_next = row_in_range ? S_CURSOR_WAIT : S_OUT;
      S_CURSOR_WAIT: state_next = S_EMIT_RD;
      S_EMIT_RD:     state_next = S_EMIT;
      S_EMIT:        state_next = S_OUT;
      S_OUT:         state_next = out_free ? S_IDLE : S_OUT;
      default:       state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      blk_len   <= '0;
      emitted   <= '0;
      start_row <= '0;
      cursor    <= '0;
      built     <= 1'b0;
      cnt_vld   <= '0;
      out_valid <= 1'b0;
      p_vld     <= 1'b0;
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      f_vld     <= 1'b0;
    end else begin
      state <= state_next;
      // In S_OUT the output register is reloaded below instead.
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (cmd)
              CMD_HEADER: begin
                cnt_vld   <= '0;
                blk_len   <= '0;
                start_row <= primary_index;
                cursor    <= '0;
                emitted   <= '0;
                built     <= 1'b0;
              end
              CMD_DATA: begin
                if (data_ok) begin
                  blk_len <= blk_len + CW'(1);
                  cnt_sym <= data_byte[SW-1:0];
                  cnt_rv  <= cnt_vld[data_byte[SW-1:0]];
                end
              end
              CMD_READ: begin
                res_byte <= '0;
                res_last <= 1'b0;
                if (read_empty) begin
                  res_status <= ST_EMPTY;
                end else if (!built) begin
                  sweep <= '0;
                  psum  <= '0;
                  p_vld <= 1'b0;
                end else if (!row_in_range) begin
                  res_status <= ST_RANGE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_COUNT: begin
          cnt_vld[cnt_sym] <= 1'b1;
        end
        S_PREFIX: begin
          if (sweep_more) begin
            sweep <= sweep + RW'(1);
            p_vld <= 1'b1;
            p_sym <= sweep[SW-1:0];
            p_v   <= cnt_vld[sweep[SW-1:0]];
          end else begin
            p_vld <= 1'b0;
          end
          if (p_vld) begin
            psum           <= psum + (p_v ? cnt_rdata : '0);
            cnt_vld[p_sym] <= 1'b1;
          end
          if (!sweep_more && !p_vld) begin
            scan_idx <= '0;
            a_vld    <= 1'b0;
            b_vld    <= 1'b0;
            f_vld    <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            scan_idx <= scan_idx + CW'(1);
            a_vld    <= 1'b1;
            a_idx    <= scan_idx[AW-1:0];
          end else begin
            a_vld <= 1'b0;
          end
          b_vld <= a_vld;
          b_idx <= a_idx;
          b_sym <= bs_rdata[SW-1:0];
          f_vld <= b_vld;
          f_sym <= b_sym;
          f_val <= scan_pos + CW'(1);
        end
        S_CURSOR: begin
          built <= 1'b1;
          if (!row_in_range) begin
            res_status <= ST_RANGE;
          end
        end
        S_CURSOR_WAIT: begin
          cursor <= nrt_rdata;
        end
        S_EMIT_RD: begin
        end
        S_EMIT: begin
          res_byte   <= bs_rdata;
          res_last   <= ((emitted + CW'(1)) == blk_len);
          res_status <= ST_OK;
          cursor     <= nrt_rdata;
          emitted    <= emitted + CW'(1);
        end
        S_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            decoded_byte <= res_byte;
            last_byte    <= res_last;
            status       <= res_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_emitted_bounded: assert property (@(posedge clk) disable iff (rst)
    emitted <= blk_len)
    else $error("more bytes emitted than the block holds");

  a_built_counts_valid: assert property (@(posedge clk) disable iff (rst)
    built |-> (&cnt_vld))
    else $error("table marked built before every symbol count was summed");

  a_table_write_in_block: assert property (@(posedge clk) disable iff (rst)
    nrt_we |-> (CW'(nrt_waddr) < blk_len))
    else $error("next-row write outside the loaded block");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT && out_valid))
    else $error("result overwrote a stalled output");
`endif

endmodule
